// ===== src/stick_to_pointer_motion_top_macros.svh =====
// Assertion macros shared by the stick to pointer motion block.
`ifndef STICK_TO_POINTER_MOTION_TOP_MACROS_SVH
`define STICK_TO_POINTER_MOTION_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while reset is low.
`define STP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stp assertion failed");

// Next-cycle implication, sampled on clk, off while reset is low.
`define STP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stp assertion failed");

`endif

// ===== src/stp_pkg.sv =====
// Shared types, constants and helpers of the stick to pointer motion block.
package stp_pkg;

    localparam int FRAC_BITS_DEF = 16;

    // fixed operand widths of the datapath
    localparam int MG_W  = 31;   // |axis| * gain
    localparam int SA_W  = 63;   // scroll numerator
    localparam int DEN_W = 35;   // divisor width

    localparam logic [19:0] US_PER_S  = 20'd1000000;
    localparam logic [14:0] AXIS_FULL = 15'd32767;

    // configuration register indexes
    localparam logic [1:0] CFG_DEAD_ZONE    = 2'd0;
    localparam logic [1:0] CFG_POINTER_GAIN = 2'd1;
    localparam logic [1:0] CFG_SMOOTHING    = 2'd2;
    localparam logic [1:0] CFG_SCROLL_GAIN  = 2'd3;

    localparam logic [14:0] DEAD_ZONE_RST = 15'd8000;
    localparam logic [15:0] PTR_GAIN_RST  = 16'd1000;
    localparam logic [15:0] SMOOTH_RST    = 16'd6554;
    localparam logic [15:0] SCR_GAIN_RST  = 16'd2500;

    // datapath operations
    localparam logic [3:0] OP_NONE  = 4'd0;
    localparam logic [3:0] OP_LOAD  = 4'd1;
    localparam logic [3:0] OP_PREP  = 4'd2;
    localparam logic [3:0] OP_PREP2 = 4'd3;
    localparam logic [3:0] OP_DIVX  = 4'd4;
    localparam logic [3:0] OP_SMX1  = 4'd5;
    localparam logic [3:0] OP_SMX2  = 4'd6;
    localparam logic [3:0] OP_DIVY  = 4'd7;
    localparam logic [3:0] OP_SMY1  = 4'd8;
    localparam logic [3:0] OP_SMY2  = 4'd9;
    localparam logic [3:0] OP_STEP  = 4'd10;
    localparam logic [3:0] OP_DIVS  = 4'd11;
    localparam logic [3:0] OP_SCR   = 4'd12;

    typedef struct packed {
        logic signed [15:0] stick_x;
        logic signed [15:0] stick_y;
        logic               scroll_hold;
        logic               cursor_shown;
        logic [19:0]        elapsed_us;
    } in_t;

    typedef struct packed {
        logic signed [15:0] move_dx;
        logic signed [15:0] move_dy;
        logic               move_valid;
        logic signed [15:0] scroll_amount;
        logic               scroll_valid;
    } out_t;

    typedef struct packed {
        logic [3:0] op;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic div_busy;
    } sts_t;

    function automatic logic [16:0] mag16(logic signed [15:0] v);
        logic signed [16:0] e;
        e = 17'(v);
        return v[15] ? 17'(-e) : 17'(e);
    endfunction

    function automatic logic signed [15:0] sat16(logic signed [19:0] v);
        logic signed [15:0] r;
        if (v > 20'sd32767)
            r = 16'sh7FFF;
        else if (v < -20'sd32768)
            r = 16'sh8000;
        else
            r = v[15:0];
        return r;
    endfunction

endpackage

// ===== src/stick_to_pointer_motion_top.sv =====
// Top level of the stick to pointer motion block.
//
//   channel   signals                          payload
//   input     in_valid / in_stall / in_data    one poll (in_t)
//   output    out_valid / out_stall / out_data one result (out_t)
//   config    cfg_we / cfg_index / cfg_data    one register write
//
// One poll runs the serial divider for both axes and the wheel in turn; the
// divider sets how long a poll takes.
// Reset restores register defaults and clears all motion state; no sweep runs.
// A stalled output holds its result; the next poll is taken while it waits.
module stick_to_pointer_motion_top import stp_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_t         in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output out_t        out_data,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    `include "stick_to_pointer_motion_top_macros.svh"

    cmd_t cmd;
    sts_t sts;

    stp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    stp_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_data  (out_data)
    );

    `STP_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
    `STP_ASSERT_NOW(a_move_xor_scroll, out_valid,
                    !(out_data.move_valid && out_data.scroll_valid))
    `STP_ASSERT_NOW(a_idle_move_zero, out_valid && !out_data.move_valid,
                    out_data.move_dx == 16'sd0 && out_data.move_dy == 16'sd0)
    `STP_ASSERT_NOW(a_idle_scroll_zero, out_valid && !out_data.scroll_valid,
                    out_data.scroll_amount == 16'sd0)

endmodule

// ===== src/stp_div.sv =====
// Restoring serial divider, one quotient bit per cycle, saturating quotient.
module stp_div import stp_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    localparam int NW = SA_W + FRAC_BITS,
    localparam int QW = FRAC_BITS + 17,
    localparam int CW = $clog2(NW + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [NW-1:0]     num,
    input  logic [DEN_W-1:0]  den,
    input  logic [CW-1:0]     nbits,
    output logic              busy,
    output logic [QW-1:0]     quo
);

    logic [NW-1:0]    num_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W:0]   rem_reg;
    logic [QW-1:0]    q_reg;
    logic             ovf_reg;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg;

    logic [DEN_W:0]   shift_next;
    logic             ge_next;
    logic [DEN_W:0]   rem_next;

    always_comb
    begin
        shift_next = {rem_reg[DEN_W-1:0], num_reg[NW-1]};
        ge_next    = shift_next >= {1'b0, den_reg};
        rem_next   = ge_next ? shift_next - {1'b0, den_reg} : shift_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= nbits;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
            q_reg   <= '0;
            ovf_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[NW-2:0], 1'b0};
            rem_reg <= rem_next;
            q_reg   <= {q_reg[QW-2:0], ge_next};
            ovf_reg <= ovf_reg | q_reg[QW-1];
        end
    end

    assign busy = busy_reg;
    assign quo  = ovf_reg ? '1 : q_reg;

endmodule

// ===== src/stp_dp.sv =====
// Datapath: configuration, poll timers, velocity smoothing, step and wheel arithmetic.
module stp_dp import stp_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  in_t         in_data,
    input  cmd_t        cmd,
    output sts_t        sts,
    output out_t        out_data
);

    localparam int F   = FRAC_BITS;
    localparam int SVW = F + 18;
    localparam int FW  = F + 1;
    localparam int QW  = F + 17;
    localparam int NW  = SA_W + F;
    localparam int CW  = $clog2(NW + 1);
    localparam int PW  = SVW + 18;
    localparam int AW  = SVW + 1;
    localparam logic signed [AW-1:0] LIM_V = AW'({2'b00, {QW{1'b1}}});

    // configuration
    logic [14:0] dz_reg;
    logic [15:0] pg_reg, sf_reg, sg_reg;

    // model state
    logic [19:0] poll_count_reg, poll_rate_reg;
    logic [20:0] window_time_reg;
    logic [31:0] scroll_time_reg;
    logic signed [SVW-1:0] svx_reg, svy_reg, sacc_reg;
    logic signed [FW-1:0]  frx_reg, fry_reg;

    // per-request working registers
    logic signed [15:0] xz_reg, yz_reg;
    logic               hold_reg, shown_reg;
    logic [31:0]        dt_reg;
    logic [MG_W-1:0]    mgx_reg, mgy_reg, snum_reg;
    logic [DEN_W-1:0]   rden_reg, sden_reg;
    logic [SA_W-1:0]    sa_reg;
    logic signed [PW-1:0] prod_reg;
    out_t               res_reg, out_reg;

    // divider hookup
    logic          div_start, div_busy;
    logic [NW-1:0] div_num;
    logic [DEN_W-1:0] div_den;
    logic [CW-1:0] div_bits;
    logic [QW-1:0] div_q;

    // load stage
    logic signed [15:0] xz_next, yz_next;
    logic [19:0] pc_next;
    logic [20:0] wt_next;
    logic [32:0] st_sum;
    logic [31:0] st_next;

    // prep stage
    logic [16:0] magx, magy;
    logic [32:0] mgx_full, mgy_full;
    logic [15:0] ydiff;
    logic [31:0] snum_full;
    logic [DEN_W-1:0] rden_next, sden_next;
    logic [SA_W-1:0] sa_next;

    // smoothing
    logic               y_sel1, y_sel2;
    logic signed [15:0] axis1;
    logic signed [SVW-1:0] tv, sv1, sv2, sv_next;
    logic signed [SVW:0]   diff;
    logic signed [PW-1:0]  prod_next, prod_b;
    logic signed [SVW+1:0] sm_sum;

    // pointer step
    logic signed [AW-1:0] accx, accy, bx, by;
    logic signed [18:0]   mx, my;
    logic signed [AW-1:0] remx, remy;
    logic signed [15:0]   dx_next, dy_next;

    // wheel
    logic signed [AW-1:0] sinc, ssum, sclip, sb, srem;
    logic signed [18:0]   w;
    logic signed [15:0]   wheel_next;

    always_comb
    begin
        xz_next = (mag16(in_data.stick_x) < {2'b00, dz_reg}) ? 16'sd0 : in_data.stick_x;
        yz_next = (mag16(in_data.stick_y) < {2'b00, dz_reg}) ? 16'sd0 : in_data.stick_y;
        pc_next = (poll_count_reg == '1) ? poll_count_reg : poll_count_reg + 20'd1;
        wt_next = window_time_reg + {1'b0, in_data.elapsed_us};
        st_sum  = {1'b0, scroll_time_reg} + {13'd0, in_data.elapsed_us};
        st_next = st_sum[32] ? '1 : st_sum[31:0];

        magx      = mag16(xz_reg);
        magy      = mag16(yz_reg);
        mgx_full  = magx * pg_reg;
        mgy_full  = magy * pg_reg;
        ydiff     = 16'(magy - {2'b00, dz_reg});
        snum_full = ydiff * sg_reg;
        rden_next = DEN_W'(poll_rate_reg) * DEN_W'(AXIS_FULL);
        sden_next = DEN_W'(AXIS_FULL - dz_reg) * DEN_W'(US_PER_S);
        sa_next   = SA_W'(snum_reg) * SA_W'(dt_reg);

        // target velocity from the quotient, then its blend step
        y_sel1 = cmd.op == OP_SMY1;
        axis1  = y_sel1 ? yz_reg : xz_reg;
        sv1    = y_sel1 ? svy_reg : svx_reg;
        if (poll_rate_reg == 20'd0 || axis1 == 16'sd0)
            tv = '0;
        else if (axis1[15])
            tv = -$signed({1'b0, div_q});
        else
            tv = $signed({1'b0, div_q});
        diff      = (SVW+1)'(tv) - (SVW+1)'(sv1);
        prod_next = PW'(diff * $signed({1'b0, sf_reg}));

        // divide by 2^16 toward zero
        y_sel2  = cmd.op == OP_SMY2;
        sv2     = y_sel2 ? svy_reg : svx_reg;
        prod_b  = prod_reg + $signed({{(PW-16){1'b0}}, {16{prod_reg[PW-1]}}});
        sm_sum  = (SVW+2)'(sv2) + prod_b[PW-1:16];
        sv_next = sm_sum[SVW-1:0];

        // whole steps toward zero, remainder carried
        accx = AW'(frx_reg) + AW'(svx_reg);
        accy = AW'(fry_reg) + AW'(svy_reg);
        bx   = accx + $signed({{(AW-F){1'b0}}, {F{accx[AW-1]}}});
        by   = accy + $signed({{(AW-F){1'b0}}, {F{accy[AW-1]}}});
        mx   = bx[AW-1:F];
        my   = by[AW-1:F];
        remx = accx - $signed({mx, {F{1'b0}}});
        remy = accy - $signed({my, {F{1'b0}}});
        dx_next = sat16(20'(mx));
        dy_next = sat16(-(20'(my)));

        // wheel accumulate, clip, emit whole part
        if (dz_reg == AXIS_FULL)
            sinc = '0;
        else if (yz_reg[15])
            sinc = -$signed({2'b00, div_q});
        else
            sinc = $signed({2'b00, div_q});
        ssum = AW'(sacc_reg) + sinc;
        if (ssum > LIM_V)
            sclip = LIM_V;
        else if (ssum < -LIM_V)
            sclip = -LIM_V;
        else
            sclip = ssum;
        sb   = sclip + $signed({{(AW-F){1'b0}}, {F{sclip[AW-1]}}});
        w    = sb[AW-1:F];
        srem = sclip - $signed({w, {F{1'b0}}});
        wheel_next = sat16(20'(w));

        div_start = 1'b0;
        div_num   = '0;
        div_den   = rden_reg;
        div_bits  = CW'(MG_W + F);
        case (cmd.op)
            OP_DIVX:
            begin
                div_start = 1'b1;
                div_num   = {mgx_reg, {(NW-MG_W){1'b0}}};
            end
            OP_DIVY:
            begin
                div_start = 1'b1;
                div_num   = {mgy_reg, {(NW-MG_W){1'b0}}};
            end
            OP_DIVS:
            begin
                div_start = 1'b1;
                div_num   = {sa_reg, {F{1'b0}}};
                div_den   = sden_reg;
                div_bits  = CW'(NW);
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    stp_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .nbits (div_bits),
        .busy  (div_busy),
        .quo   (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dz_reg          <= DEAD_ZONE_RST;
            pg_reg          <= PTR_GAIN_RST;
            sf_reg          <= SMOOTH_RST;
            sg_reg          <= SCR_GAIN_RST;
            poll_count_reg  <= '0;
            poll_rate_reg   <= '0;
            window_time_reg <= '0;
            scroll_time_reg <= '0;
            svx_reg         <= '0;
            svy_reg         <= '0;
            sacc_reg        <= '0;
            frx_reg         <= '0;
            fry_reg         <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_DEAD_ZONE:    dz_reg <= cfg_data[14:0];
                    CFG_POINTER_GAIN: pg_reg <= cfg_data;
                    CFG_SMOOTHING:    sf_reg <= cfg_data;
                    CFG_SCROLL_GAIN:  sg_reg <= cfg_data;
                    default:          dz_reg <= dz_reg;
                endcase
            end
            case (cmd.op)
                OP_LOAD:
                begin
                    if (wt_next >= {1'b0, US_PER_S})
                    begin
                        poll_rate_reg   <= pc_next;
                        poll_count_reg  <= '0;
                        window_time_reg <= '0;
                    end
                    else
                    begin
                        poll_count_reg  <= pc_next;
                        window_time_reg <= wt_next;
                    end
                    scroll_time_reg <= (in_data.cursor_shown && in_data.scroll_hold) ?
                                       32'd0 : st_next;
                end
                OP_SMX2:
                begin
                    if (shown_reg)
                        svx_reg <= sv_next;
                end
                OP_SMY2:
                begin
                    if (shown_reg)
                        svy_reg <= sv_next;
                end
                OP_STEP:
                begin
                    if (shown_reg)
                    begin
                        frx_reg <= remx[FW-1:0];
                        fry_reg <= remy[FW-1:0];
                    end
                end
                OP_SCR:
                begin
                    if (shown_reg && hold_reg)
                        sacc_reg <= (yz_reg == 16'sd0) ? '0 : srem[SVW-1:0];
                end
                default:
                begin
                    sacc_reg <= sacc_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                xz_reg    <= xz_next;
                yz_reg    <= yz_next;
                hold_reg  <= in_data.scroll_hold;
                shown_reg <= in_data.cursor_shown;
                dt_reg    <= st_next;
                res_reg   <= '0;
            end
            OP_PREP:
            begin
                mgx_reg  <= mgx_full[MG_W-1:0];
                mgy_reg  <= mgy_full[MG_W-1:0];
                snum_reg <= snum_full[MG_W-1:0];
                rden_reg <= rden_next;
                sden_reg <= sden_next;
            end
            OP_PREP2:
            begin
                sa_reg <= sa_next;
            end
            OP_SMX1, OP_SMY1:
            begin
                prod_reg <= prod_next;
            end
            OP_STEP:
            begin
                if (shown_reg && !hold_reg && (mx != 19'sd0 || my != 19'sd0))
                begin
                    res_reg.move_dx    <= dx_next;
                    res_reg.move_dy    <= dy_next;
                    res_reg.move_valid <= 1'b1;
                end
            end
            OP_SCR:
            begin
                if (shown_reg && hold_reg && yz_reg != 16'sd0 && w != 19'sd0)
                begin
                    res_reg.scroll_amount <= wheel_next;
                    res_reg.scroll_valid  <= 1'b1;
                end
            end
            default:
            begin
                res_reg <= res_reg;
            end
        endcase
        if (cmd.out_load)
            out_reg <= res_reg;
    end

    assign sts.div_busy = div_busy;
    assign out_data     = out_reg;

endmodule

// ===== src/stp_ctrl.sv =====
// Controller: sequences one poll through the datapath and owns both handshakes.
module stp_ctrl import stp_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    output logic out_valid,
    input  logic out_stall,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PREP  = 4'd1;
    localparam logic [3:0] S_PREP2 = 4'd2;
    localparam logic [3:0] S_DXS   = 4'd3;
    localparam logic [3:0] S_DXW   = 4'd4;
    localparam logic [3:0] S_SX1   = 4'd5;
    localparam logic [3:0] S_SX2   = 4'd6;
    localparam logic [3:0] S_DYS   = 4'd7;
    localparam logic [3:0] S_DYW   = 4'd8;
    localparam logic [3:0] S_SY1   = 4'd9;
    localparam logic [3:0] S_SY2   = 4'd10;
    localparam logic [3:0] S_STEP  = 4'd11;
    localparam logic [3:0] S_DSS   = 4'd12;
    localparam logic [3:0] S_DSW   = 4'd13;
    localparam logic [3:0] S_SCR   = 4'd14;
    localparam logic [3:0] S_OUT   = 4'd15;

    logic [3:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    always_comb
    begin
        out_free       = !out_valid_reg || !out_stall;
        state_next     = state_reg;
        cmd.op         = OP_NONE;
        cmd.out_load   = 1'b0;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_PREP;
                end
            end
            S_PREP:  begin cmd.op = OP_PREP;  state_next = S_PREP2; end
            S_PREP2: begin cmd.op = OP_PREP2; state_next = S_DXS;   end
            S_DXS:   begin cmd.op = OP_DIVX;  state_next = S_DXW;   end
            S_DXW:
            begin
                if (!sts.div_busy)
                    state_next = S_SX1;
            end
            S_SX1:   begin cmd.op = OP_SMX1;  state_next = S_SX2;   end
            S_SX2:   begin cmd.op = OP_SMX2;  state_next = S_DYS;   end
            S_DYS:   begin cmd.op = OP_DIVY;  state_next = S_DYW;   end
            S_DYW:
            begin
                if (!sts.div_busy)
                    state_next = S_SY1;
            end
            S_SY1:   begin cmd.op = OP_SMY1;  state_next = S_SY2;   end
            S_SY2:   begin cmd.op = OP_SMY2;  state_next = S_STEP;  end
            S_STEP:  begin cmd.op = OP_STEP;  state_next = S_DSS;   end
            S_DSS:   begin cmd.op = OP_DIVS;  state_next = S_DSW;   end
            S_DSW:
            begin
                if (!sts.div_busy)
                    state_next = S_SCR;
            end
            S_SCR:   begin cmd.op = OP_SCR;   state_next = S_OUT;   end
            S_OUT:
            begin
                // hold the result until the output register frees up
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = state_reg != S_IDLE;
    assign out_valid = out_valid_reg;

endmodule
